@@ design/jsh_pkg.sv @@
// Package for the jitter statistics histogram block.
// Holds command codes, state types, queue entry and status types, shared constants and a saturating increment.
// No dependencies.
package jsh_pkg;

    // Histogram geometry
    localparam int HIST_BINS = 32;
    localparam int BIN_W = $clog2(HIST_BINS);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(HIST_BINS - 1);

    // Field widths fixed by the interface
    localparam int CMD_W = 2;
    localparam int TICK_W = 48;
    localparam int JIT_W = 32;
    localparam int EXEC_W = 32;
    localparam int SEL_W = 5;
    localparam int MEAN_W = 48;
    localparam int CNT_W = 32;
    localparam int FRAC_W = 16;

    // Configuration registers
    localparam int WIDTH_W = 20;
    localparam int ALPHA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b1;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 20'd1000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(JIT_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(JIT_W - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 2'd0,
        CMD_OVERRUN     = 2'd1,
        CMD_RESET_WORST = 2'd2,
        CMD_READ_BIN    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD_BIN,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_UPDATE,
        B_RD_SEL,
        B_OUT
    } back_state_t;

    // One classified command waiting for the back end
    typedef struct packed {
        cmd_t              cmd;
        logic [TICK_W-1:0] tick;
        logic [JIT_W-1:0]  jitter;
        logic [EXEC_W-1:0] exec;
        logic [SEL_W-1:0]  sel;
        logic [BIN_W-1:0]  bin;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Saturating increment of a 32-bit counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

@@ design/jsh_if.sv @@
// Channel interfaces for the jitter statistics histogram block.
// Depends on jsh_pkg for field widths.
interface jsh_in_if
    import jsh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TICK_W-1:0] tick_number;
    logic [JIT_W-1:0]  jitter_sample;
    logic [EXEC_W-1:0] exec_time;
    logic [SEL_W-1:0]  bin_select;

    modport source (output valid, command, tick_number, jitter_sample, exec_time, bin_select,
                    input ready);
    modport sink (input valid, command, tick_number, jitter_sample, exec_time, bin_select,
                  output ready);
endinterface

interface jsh_out_if
    import jsh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] last_tick;
    logic [JIT_W-1:0]  last_jitter;
    logic [MEAN_W-1:0] mean_jitter;
    logic [JIT_W-1:0]  worst_jitter;
    logic [EXEC_W-1:0] last_exec;
    logic [CNT_W-1:0]  overruns;
    logic [SEL_W-1:0]  bin_index;
    logic [CNT_W-1:0]  bin_count;

    modport source (output valid, last_tick, last_jitter, mean_jitter, worst_jitter,
                    last_exec, overruns, bin_index, bin_count,
                    input ready);
    modport sink (input valid, last_tick, last_jitter, mean_jitter, worst_jitter,
                  last_exec, overruns, bin_index, bin_count,
                  output ready);
endinterface

@@ design/jsh_queue.sv @@
// Short queue of classified commands between the front and back ends.
// Depends on jsh_pkg.
module jsh_queue
    import jsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t status
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

@@ design/jsh_front.sv @@
// Front end: takes command transfers, finds the histogram bin of a tick with a
// bit-serial divider and places the classified command in the queue.
// Depends on jsh_pkg and jsh_if.
module jsh_front
    import jsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    jsh_in_if.sink             samples,
    input  logic [WIDTH_W-1:0] bin_width,
    input  q_status_t          q_status,
    output logic               push,
    output entry_t             push_entry
);

    front_state_t         state_reg, state_next;
    entry_t               item_reg;
    logic [JIT_W-1:0]     dvd_reg, dvd_next;
    logic [WIDTH_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 accept;
    logic [WIDTH_W:0]     rem_shift;
    logic                 fits;
    logic [BIN_W-1:0]     bin_clamped;

    assign accept = samples.valid && samples.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(samples.command) == CMD_TICK && bin_width != '0)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        samples.ready = (state_reg == F_IDLE);
        push          = (state_reg == F_PUSH) && !q_status.full;
    end

    // One restoring division step per cycle; quotient bits enter at the bottom
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[JIT_W-1]};
        fits      = (rem_shift >= {1'b0, bin_width});
        rem_next  = fits ? WIDTH_W'(rem_shift - {1'b0, bin_width}) : rem_shift[WIDTH_W-1:0];
        dvd_next  = {dvd_reg[JIT_W-2:0], fits};
    end

    // Clamp the quotient to the last bin
    always_comb
    begin
        if (dvd_reg >= JIT_W'(HIST_BINS - 1))
        begin
            bin_clamped = BIN_LAST;
        end
        else
        begin
            bin_clamped = dvd_reg[BIN_W-1:0];
        end
    end

    always_comb
    begin
        push_entry     = item_reg;
        push_entry.bin = (item_reg.bin == BIN_LAST) ? BIN_LAST : bin_clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item capture and divider datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd    <= cmd_t'(samples.command);
            item_reg.tick   <= samples.tick_number;
            item_reg.jitter <= samples.jitter_sample;
            item_reg.exec   <= samples.exec_time;
            item_reg.sel    <= samples.bin_select;
            // A zero bin width sends the sample straight to the last bin.
            item_reg.bin    <= (bin_width == '0) ? BIN_LAST : '0;
            dvd_reg         <= samples.jitter_sample;
            rem_reg         <= '0;
            cnt_reg         <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

@@ design/jsh_back.sv @@
// Back end: carries out queued commands on the statistics registers and the
// histogram memory, and holds the result snapshot in an output register.
// Depends on jsh_pkg and jsh_if.
module jsh_back
    import jsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ALPHA_W-1:0] alpha,
    input  entry_t             head,
    input  q_status_t          q_status,
    output logic               pop,
    jsh_out_if.source          results
);

    back_state_t state_reg, state_next;
    entry_t      item_reg;

    // Statistics registers
    logic [TICK_W-1:0] tick_reg;
    logic [JIT_W-1:0]  jitter_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [JIT_W-1:0]  max_reg;
    logic [EXEC_W-1:0] exec_reg;
    logic [CNT_W-1:0]  overrun_reg;

    // Mean update datapath
    logic [MEAN_W-1:0]         s_fx;
    logic                      ge_reg;
    logic                      zero_reg;
    logic [MEAN_W-1:0]         diff_reg;
    logic [JIT_W+ALPHA_W-1:0]  plo_reg;
    logic [ALPHA_W+ALPHA_W-1:0] phi_reg;
    logic [MEAN_W-1:0]         step_reg;

    // Histogram memory with per-bin valid flags
    logic [CNT_W-1:0]     hist_mem [HIST_BINS];
    logic [HIST_BINS-1:0] hist_vld_reg;
    logic [CNT_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic                 rd_en;
    logic [BIN_W-1:0]     rd_addr;
    logic                 hist_we;
    logic                 sel_in_range;
    logic                 load_out;

    // Output register
    logic              out_valid_reg;
    logic [TICK_W-1:0] o_tick_reg;
    logic [JIT_W-1:0]  o_jitter_reg;
    logic [MEAN_W-1:0] o_mean_reg;
    logic [JIT_W-1:0]  o_worst_reg;
    logic [EXEC_W-1:0] o_exec_reg;
    logic [CNT_W-1:0]  o_overrun_reg;
    logic [SEL_W-1:0]  o_index_reg;
    logic [CNT_W-1:0]  o_count_reg;

    assign s_fx         = {item_reg.jitter, {FRAC_W{1'b0}}};
    assign sel_in_range = (32'(item_reg.sel) < 32'(HIST_BINS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head.cmd == CMD_TICK) ? B_RD_BIN : B_UPDATE;
                end
            end
            B_RD_BIN: state_next = B_MUL_LO;
            B_MUL_LO: state_next = B_MUL_HI;
            B_MUL_HI: state_next = B_SUM;
            B_SUM:    state_next = B_UPDATE;
            B_UPDATE: state_next = B_RD_SEL;
            B_RD_SEL: state_next = B_OUT;
            B_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop      = (state_reg == B_IDLE) && !q_status.empty;
        rd_en    = (state_reg == B_RD_BIN) || (state_reg == B_RD_SEL);
        rd_addr  = (state_reg == B_RD_SEL) ? BIN_W'(item_reg.sel) : item_reg.bin;
        hist_we  = (state_reg == B_UPDATE) && (item_reg.cmd == CMD_TICK);
        load_out = (state_reg == B_OUT) && (!out_valid_reg || results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command capture and mean arithmetic, one multiplier half per cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        case (state_reg)
            B_RD_BIN:
            begin
                zero_reg <= (mean_reg == '0);
                ge_reg   <= (s_fx >= mean_reg);
                diff_reg <= (s_fx >= mean_reg) ? s_fx - mean_reg : mean_reg - s_fx;
            end
            B_MUL_LO: plo_reg <= diff_reg[JIT_W-1:0] * alpha;
            B_MUL_HI: phi_reg <= diff_reg[MEAN_W-1:JIT_W] * alpha;
            B_SUM:
            begin
                step_reg <= MEAN_W'({phi_reg, {FRAC_W{1'b0}}})
                          + MEAN_W'(plo_reg[JIT_W+ALPHA_W-1:FRAC_W]);
            end
            default:
            begin
            end
        endcase
    end

    // Statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            jitter_reg  <= '0;
            mean_reg    <= '0;
            max_reg     <= '0;
            exec_reg    <= '0;
            overrun_reg <= '0;
        end
        else if (state_reg == B_UPDATE)
        begin
            case (item_reg.cmd)
                CMD_TICK:
                begin
                    tick_reg   <= item_reg.tick;
                    jitter_reg <= item_reg.jitter;
                    exec_reg   <= item_reg.exec;
                    if (zero_reg)
                    begin
                        mean_reg <= s_fx;
                    end
                    else if (ge_reg)
                    begin
                        mean_reg <= mean_reg + step_reg;
                    end
                    else
                    begin
                        mean_reg <= mean_reg - step_reg;
                    end
                    if (item_reg.jitter > max_reg)
                    begin
                        max_reg <= item_reg.jitter;
                    end
                end
                CMD_OVERRUN:
                begin
                    overrun_reg <= sat_inc(overrun_reg);
                end
                CMD_RESET_WORST:
                begin
                    max_reg     <= '0;
                    overrun_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Histogram memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[item_reg.bin] <= rd_vld_reg ? sat_inc(rd_data_reg) : CNT_W'(1);
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // A bin that is not valid reads as zero; reset worst clears all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if ((state_reg == B_UPDATE) && (item_reg.cmd == CMD_RESET_WORST))
            begin
                hist_vld_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[item_reg.bin] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= hist_vld_reg[rd_addr];
            end
        end
    end

    // Result register; the next command proceeds while a result waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_tick_reg    <= tick_reg;
            o_jitter_reg  <= jitter_reg;
            o_mean_reg    <= mean_reg;
            o_worst_reg   <= max_reg;
            o_exec_reg    <= exec_reg;
            o_overrun_reg <= overrun_reg;
            o_index_reg   <= item_reg.sel;
            o_count_reg   <= (sel_in_range && rd_vld_reg) ? rd_data_reg : '0;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.last_tick    = o_tick_reg;
    assign results.last_jitter  = o_jitter_reg;
    assign results.mean_jitter  = o_mean_reg;
    assign results.worst_jitter = o_worst_reg;
    assign results.last_exec    = o_exec_reg;
    assign results.overruns     = o_overrun_reg;
    assign results.bin_index    = o_index_reg;
    assign results.bin_count    = o_count_reg;

    // The histogram is only written while a tick is carried out.
    a_hist_write: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (state_reg == B_UPDATE) && !pop)
        else $error("histogram written outside a tick update");

    // A command is only taken from the queue when one is there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");

    // A new result appears only out of the result state.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_OUT))
        else $error("result register loaded outside the result state");

    // After a tick the worst jitter covers the last jitter.
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_UPDATE) && (item_reg.cmd == CMD_TICK) |=> (max_reg >= jitter_reg))
        else $error("running maximum below last jitter");

endmodule

@@ design/jitter_stats_histogram.sv @@
// Jitter statistics block: per-command snapshot of last tick, smoothed mean,
// worst jitter, overrun count and one histogram bin count.
// Depends on jsh_pkg, jsh_if, jsh_queue, jsh_front and jsh_back.
//
// Every command transfer on the samples channel yields exactly one result
// transfer. A record-tick command occupies the front end while the bit-serial
// divider finds the histogram bin one quotient bit per cycle; with a zero bin
// width, and for other commands, the divider is skipped. For a tick the back
// end reads the bin, updates the mean through a split 32x16 multiplier (low
// half, high half, sum), writes the bin and reads the selected bin; other
// commands skip the bin read and the mean arithmetic. A two-entry queue
// between the two halves and a result register let each side stall on its
// own. The histogram is valid straight after reset, without a clearing pass.
// Configuration writes are only to be made while no command is in flight.
module jitter_stats_histogram
    import jsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jsh_in_if.sink                samples,
    jsh_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WIDTH_W-1:0] bin_width_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               push;
    logic               pop;
    entry_t             push_entry;
    entry_t             head;
    q_status_t          q_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= BIN_WIDTH_RESET;
            alpha_reg     <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIN_WIDTH: bin_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_ALPHA:     alpha_reg     <= cfg_data[ALPHA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    jsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .bin_width  (bin_width_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    jsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    jsh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .alpha    (alpha_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .results  (results)
    );

endmodule
